// ===== hdl/serial_frame_deframer_xor_check_core_assert.svh =====
// Assertion macros shared by the deframer RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef SERIAL_FRAME_DEFRAMER_XOR_CHECK_CORE_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_XOR_CHECK_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sfd_pkg.sv =====
// Shared types and constants for the serial frame deframer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  // Configuration register indexes and their reset values.
  localparam logic [7:0] CFG_MAGIC_FIRST  = 8'd0;
  localparam logic [7:0] CFG_MAGIC_SECOND = 8'd1;
  localparam logic [7:0] MAGIC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] MAGIC_SECOND_RST = 8'h55;

  // Result stream packing.
  localparam int OUT_FIELDS_W = 73;
  localparam int OUT_TDATA_W  = 80;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ID      = 2'd0,
    KIND_VALUE   = 2'd1,
    KIND_VERDICT = 2'd2,
    KIND_ABORT   = 2'd3
  } kind_t;

  // Input beat held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
    logic       is_timeout;
  } in_beat_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  command_code;
    logic [7:0]  value_type;
    logic [7:0]  id_length;
    logic [15:0] value_length;
    logic        checksum_ok;
    logic [7:0]  received_checksum;
  } out_item_t;

  // Result handed from the frame logic to the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/sfd_in_stage.sv =====
// Input register of the deframer: captures one received beat.
// Depends on sfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfd_in_stage
  import sfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
  input  wire logic       s_tuser,   // [0] is_timeout
  input  wire logic       pop,
  output in_beat_t        in_beat
);

  logic       held;
  logic [7:0] rx_byte;
  logic       is_timeout;

  // Take a new beat when the register is empty or drains this cycle.
  assign s_tready = !held || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (pop) begin
      held <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      rx_byte    <= s_tdata;
      is_timeout <= s_tuser;
    end
  end

  assign in_beat = '{valid: held, rx_byte: rx_byte, is_timeout: is_timeout};

endmodule

`default_nettype wire

// ===== hdl/sfd_frame_fsm.sv =====
// Frame parser: header hunt, field capture, running XOR and result selection.
// Depends on sfd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_frame_deframer_xor_check_core_assert.svh"

module sfd_frame_fsm
  import sfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] magic_first,
  input  wire logic [7:0] magic_second,
  input  wire in_beat_t   in_beat,
  input  wire logic       space,
  output logic            pop,
  output res_t            res
);

  typedef enum logic [3:0] {
    PH_HUNT1, PH_HUNT2, PH_CMD, PH_IDLEN, PH_ID,
    PH_TYPE, PH_LENH, PH_LENL, PH_VALUE, PH_CHECK
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  command_reg, command_reg_next;
  logic [7:0]  id_len_reg, id_len_reg_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  length_high_reg, length_high_reg_next;
  logic [15:0] value_len_reg, value_len_reg_next;
  logic [15:0] byte_counter, byte_counter_next;
  logic [7:0]  xor_accum, xor_accum_next;

  logic [7:0]  b;
  logic [16:0] idx_inc;
  logic [15:0] len_full;
  out_item_t   item;
  logic        emit;

  // One beat is consumed per cycle whenever a beat is held and the output register has room.
  assign pop     = in_beat.valid && space;
  assign b       = in_beat.rx_byte;
  assign idx_inc = {1'b0, byte_counter} + 17'd1;
  assign len_full = {length_high_reg, b};

  // Next state and result for the held beat.
  always_comb begin
    phase_next           = phase;
    command_reg_next     = command_reg;
    id_len_reg_next      = id_len_reg;
    type_reg_next        = type_reg;
    length_high_reg_next = length_high_reg;
    value_len_reg_next   = value_len_reg;
    byte_counter_next    = byte_counter;
    xor_accum_next       = xor_accum;
    emit                 = 1'b0;
    item = '{kind: KIND_ABORT, data_byte: 8'd0, byte_index: 16'd0,
             command_code: command_reg, value_type: type_reg,
             id_length: id_len_reg, value_length: value_len_reg,
             checksum_ok: 1'b0, received_checksum: 8'd0};

    if (phase == PH_HUNT1 || phase == PH_HUNT2) begin
      // Header hunt; a mismatched second byte is consumed.
      if (in_beat.is_timeout) begin
        phase_next = PH_HUNT1;
      end else if (phase == PH_HUNT1) begin
        if (b == magic_first) phase_next = PH_HUNT2;
      end else if (b == magic_second) begin
        command_reg_next     = 8'd0;
        id_len_reg_next      = 8'd0;
        type_reg_next        = 8'd0;
        length_high_reg_next = 8'd0;
        value_len_reg_next   = 16'd0;
        byte_counter_next    = 16'd0;
        xor_accum_next       = 8'd0;
        phase_next           = PH_CMD;
      end else begin
        phase_next = PH_HUNT1;
      end
    end else if (in_beat.is_timeout) begin
      // Timeout inside a frame abandons it.
      emit       = 1'b1;
      phase_next = PH_HUNT1;
    end else begin
      case (phase)
        PH_CMD: begin
          command_reg_next = b;
          xor_accum_next   = xor_accum ^ b;
          phase_next       = PH_IDLEN;
        end
        PH_IDLEN: begin
          id_len_reg_next   = b;
          xor_accum_next    = xor_accum ^ b;
          byte_counter_next = 16'd0;
          phase_next        = (b == 8'd0) ? PH_TYPE : PH_ID;
        end
        PH_ID: begin
          xor_accum_next  = xor_accum ^ b;
          emit            = 1'b1;
          item.kind       = KIND_ID;
          item.data_byte  = b;
          item.byte_index = byte_counter;
          if (idx_inc >= {9'd0, id_len_reg}) begin
            byte_counter_next = 16'd0;
            phase_next        = PH_TYPE;
          end else begin
            byte_counter_next = idx_inc[15:0];
          end
        end
        PH_TYPE: begin
          type_reg_next  = b;
          xor_accum_next = xor_accum ^ b;
          phase_next     = PH_LENH;
        end
        PH_LENH: begin
          length_high_reg_next = b;
          xor_accum_next       = xor_accum ^ b;
          phase_next           = PH_LENL;
        end
        PH_LENL: begin
          value_len_reg_next = len_full;
          xor_accum_next     = xor_accum ^ b;
          byte_counter_next  = 16'd0;
          phase_next         = (len_full == 16'd0) ? PH_CHECK : PH_VALUE;
        end
        PH_VALUE: begin
          xor_accum_next  = xor_accum ^ b;
          emit            = 1'b1;
          item.kind       = KIND_VALUE;
          item.data_byte  = b;
          item.byte_index = byte_counter;
          if (idx_inc >= {1'b0, value_len_reg}) begin
            byte_counter_next = 16'd0;
            phase_next        = PH_CHECK;
          end else begin
            byte_counter_next = idx_inc[15:0];
          end
        end
        PH_CHECK: begin
          emit                   = 1'b1;
          item.kind              = KIND_VERDICT;
          item.checksum_ok       = (xor_accum == b);
          item.received_checksum = b;
          phase_next             = PH_HUNT1;
        end
        default: begin
          phase_next = PH_HUNT1;
        end
      endcase
    end
  end

  assign res = '{valid: pop && emit, item: item};

  // Frame state advances once per consumed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT1;
      command_reg     <= 8'd0;
      id_len_reg      <= 8'd0;
      type_reg        <= 8'd0;
      length_high_reg <= 8'd0;
      value_len_reg   <= 16'd0;
      byte_counter    <= 16'd0;
      xor_accum       <= 8'd0;
    end else if (pop) begin
      phase           <= phase_next;
      command_reg     <= command_reg_next;
      id_len_reg      <= id_len_reg_next;
      type_reg        <= type_reg_next;
      length_high_reg <= length_high_reg_next;
      value_len_reg   <= value_len_reg_next;
      byte_counter    <= byte_counter_next;
      xor_accum       <= xor_accum_next;
    end
  end

  // Checks on the parser.
  `SFD_ASSERT_NOW(a_id_index, res.valid && res.item.kind == KIND_ID, res.item.byte_index < {8'd0, res.item.id_length}, "id byte index beyond id length")
  `SFD_ASSERT_NOW(a_val_index, res.valid && res.item.kind == KIND_VALUE, res.item.byte_index < res.item.value_length, "value byte index beyond value length")
  `SFD_ASSERT_NOW(a_no_verdict, res.valid && res.item.kind != KIND_VERDICT, !res.item.checksum_ok && res.item.received_checksum == 8'd0, "checksum fields set outside a verdict")
  `SFD_ASSERT_NEXT(a_timeout_hunt, pop && in_beat.is_timeout, phase == PH_HUNT1, "timeout did not return to header hunt")

endmodule

`default_nettype wire

// ===== hdl/sfd_out_stage.sv =====
// Output register of the deframer: holds one result beat until taken.
// Depends on sfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfd_out_stage
  import sfd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire res_t                   res,
  output logic                        space,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [7:0] data_byte, [23:8] byte_index, [31:24] command_code,
  // [39:32] value_type, [47:40] id_length, [63:48] value_length,
  // [64] checksum_ok, [72:65] received_checksum, rest zero
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic [1:0]                  m_tuser  // [1:0] kind
);

  logic      held;
  out_item_t item;

  // Room for a new result when empty or when the held beat leaves now.
  assign space = !held || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (res.valid) begin
      held <= 1'b1;
    end else if (m_tready) begin
      held <= 1'b0;
    end
    if (res.valid) begin
      item <= res.item;
    end
  end

  // Pack the held result onto the stream.
  assign m_tvalid = held;
  assign m_tuser  = item.kind;
  assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                     item.received_checksum, item.checksum_ok,
                     item.value_length, item.id_length, item.value_type,
                     item.command_code, item.byte_index, item.data_byte};

endmodule

`default_nettype wire

// ===== hdl/serial_frame_deframer_xor_check_core.sv =====
// Serial frame deframer with XOR checksum check, top level.
// A beat passes the input register and the combinational parser into the output register.
// Throughput: one byte or timeout beat per cycle while m_tready does not stall the output.
// Synchronous active-high reset empties both stages, restores the default magic
// bytes and returns the parser to header hunt with all frame fields zero.
// Depends on sfd_pkg, sfd_in_stage, sfd_frame_fsm, sfd_out_stage.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_frame_deframer_xor_check_core_assert.svh"

module serial_frame_deframer_xor_check_core
  import sfd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,   // [7:0] rx_byte
  input  wire logic                   s_tuser,   // [0] is_timeout
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [7:0] data_byte, [23:8] byte_index, [31:24] command_code,
  // [39:32] value_type, [47:40] id_length, [63:48] value_length,
  // [64] checksum_ok, [72:65] received_checksum, rest zero
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic [1:0]                  m_tuser,   // [1:0] kind
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [7:0]             cfg_index,
  input  wire logic [7:0]             cfg_data
);

  logic [7:0] magic_first;
  logic [7:0] magic_second;
  in_beat_t   in_beat;
  res_t       res;
  logic       pop;
  logic       space;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_first  <= MAGIC_FIRST_RST;
      magic_second <= MAGIC_SECOND_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAGIC_FIRST:  magic_first  <= cfg_data;
        CFG_MAGIC_SECOND: magic_second <= cfg_data;
        default: ;
      endcase
    end
  end

  sfd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .pop      (pop),
    .in_beat  (in_beat)
  );

  sfd_frame_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .magic_first  (magic_first),
    .magic_second (magic_second),
    .in_beat      (in_beat),
    .space        (space),
    .pop          (pop),
    .res          (res)
  );

  sfd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Checks across the stages.
  `SFD_ASSERT_NOW(a_no_overwrite, m_tvalid && !m_tready, !res.valid, "result loaded over a stalled beat")
  `SFD_ASSERT_NOW(a_res_needs_pop, res.valid, pop, "result produced without consuming a beat")
  `SFD_ASSERT_NEXT(a_cfg_first, cfg_valid && cfg_index == CFG_MAGIC_FIRST, magic_first == $past(cfg_data), "first magic byte write lost")

endmodule

`default_nettype wire
